/* hw/rtl/event_trace_ring_buffer_assert.svh */
// Assertion macros used by the checker of the trace ring.
`ifndef EVENT_TRACE_RING_BUFFER_ASSERT_SVH
`define EVENT_TRACE_RING_BUFFER_ASSERT_SVH

// Checked on every clock edge once reset has been released.
`define ETRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every clock edge, reset cycles included.
`define ETRB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`endif

/* hw/rtl/etrb_pkg.sv */
`timescale 1ns / 1ps

package etrb_pkg;

    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int WORD_W   = 32;
    localparam int STAMP_W  = 64;
    localparam int CURSOR_W = 12;
    localparam int TALLY_W  = 13;
    localparam int MODE_W   = 2;

    localparam int S_FIELDS_W = 4 * WORD_W + STAMP_W + CURSOR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 4 * WORD_W + STAMP_W + TALLY_W + WORD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_EMIT  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_COUNT = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COUNT
    } state_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [WORD_W-1:0]  third;
        logic [WORD_W-1:0]  second;
        logic [WORD_W-1:0]  first;
        logic [WORD_W-1:0]  kind;
    } entry_t;

    typedef struct packed {
        logic               found;
        entry_t             entry;
        logic [TALLY_W-1:0] tally;
        logic [WORD_W-1:0]  total;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    // Number of entries held: the running total saturated at the ring depth.
    function automatic logic [CNT_W-1:0] stored_count(input logic [WORD_W-1:0] total);
        if (total >= WORD_W'(DEPTH)) begin
            return CNT_W'(DEPTH);
        end
        return total[CNT_W-1:0];
    endfunction

    // Slot of the entry that lies back steps behind the newest one.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] wp,
                                                  input logic [ADDR_W-1:0] back);
        logic [CNT_W-1:0] sum;
        sum = {1'b0, wp} + CNT_W'(DEPTH - 1) - {1'b0, back};
        if (sum >= CNT_W'(DEPTH)) begin
            sum = sum - CNT_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? ADDR_W'(DEPTH - 1) : a - 1'b1;
    endfunction

endpackage

/* hw/rtl/event_trace_ring_buffer.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// s_        in         s_tvalid / s_tready      s_tuser: mode; s_tdata: event and cursor
// m_        out        m_tvalid / m_tready      m_tuser: found; m_tdata: entry, tally, total
// cfg_      in         cfg_valid / cfg_ready    cfg_data: capture enable (cfg_ready held high)
//
// Emit and clear load the result register at the accepting edge; a read does so in the next
// cycle (one synchronous memory read); a count-kind after one memory read per stored entry.
// The next s_ beat is taken only after the result has moved to the output register, so no
// new item is taken while one is in flight. A stalled m_ holds one result and blocks s_
// once the next result is ready. Reset (aresetn, synchronous) clears position, total and
// enable; the entry memory is not cleared.

module event_trace_ring_buffer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] mode
    input  logic [etrb_pkg::MODE_W-1:0]      s_tuser,
    // [31:0] event_kind, [63:32] first_arg, [95:64] second_arg, [127:96] third_arg,
    // [191:128] stamp_in, [203:192] cursor, rest zero
    input  logic [etrb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] found
    output logic                             m_tuser,
    // [31:0] entry_kind, [63:32] entry_first, [95:64] entry_second,
    // [127:96] entry_third, [191:128] entry_stamp, [204:192] tally,
    // [236:205] grand_total, rest zero
    output logic [etrb_pkg::M_TDATA_W-1:0]   m_tdata
);

    etrb_pkg::entry_t                 s_entry;
    logic [etrb_pkg::CURSOR_W-1:0]    s_cursor;
    etrb_pkg::wr_req_t                wr;
    etrb_pkg::rd_req_t                rd;
    etrb_pkg::entry_t                 rd_data;
    logic                             res_valid;
    logic                             res_ready;
    etrb_pkg::result_t                res;

    logic                             m_valid_reg, m_valid_next;
    etrb_pkg::result_t                m_res_reg, m_res_next;

    localparam int ENTRY_W = $bits(etrb_pkg::entry_t);

    assign s_entry   = s_tdata[ENTRY_W-1:0];
    assign s_cursor  = s_tdata[ENTRY_W +: etrb_pkg::CURSOR_W];
    assign cfg_ready = 1'b1;

    etrb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_mode    (etrb_pkg::mode_t'(s_tuser)),
        .s_entry   (s_entry),
        .s_cursor  (s_cursor),
        .wr        (wr),
        .rd        (rd),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    etrb_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Output register: refilled whenever it is empty or its beat is taken.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.found;
    assign m_tdata  = etrb_pkg::M_TDATA_W'({m_res_reg.total, m_res_reg.tally,
                                            m_res_reg.entry});

endmodule

/* hw/rtl/etrb_store.sv */
`timescale 1ns / 1ps

module etrb_store (
    input  logic             aclk,
    input  etrb_pkg::wr_req_t wr,
    input  etrb_pkg::rd_req_t rd,
    output etrb_pkg::entry_t  rd_data
);

    etrb_pkg::entry_t store_mem [etrb_pkg::DEPTH];
    etrb_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            store_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= store_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/etrb_ctrl.sv */
`timescale 1ns / 1ps

module etrb_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  etrb_pkg::mode_t                   s_mode,
    input  etrb_pkg::entry_t                  s_entry,
    input  logic [etrb_pkg::CURSOR_W-1:0]     s_cursor,
    output etrb_pkg::wr_req_t                 wr,
    output etrb_pkg::rd_req_t                 rd,
    input  etrb_pkg::entry_t                  rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output etrb_pkg::result_t                 res
);

    etrb_pkg::state_t                state_reg, state_next;
    logic                            enable_reg, enable_next;
    logic [etrb_pkg::ADDR_W-1:0]     wp_reg, wp_next;
    logic [etrb_pkg::WORD_W-1:0]     total_reg, total_next;
    logic                            found_reg, found_next;
    logic [etrb_pkg::WORD_W-1:0]     kind_reg, kind_next;
    logic [etrb_pkg::CNT_W-1:0]      n_reg, n_next;
    logic [etrb_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [etrb_pkg::CNT_W-1:0]      tally_reg, tally_next;
    logic [etrb_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic                            res_valid_reg, res_valid_next;
    etrb_pkg::result_t               res_reg, res_next;

    logic                            accept;
    logic [etrb_pkg::CNT_W-1:0]      n_cur;
    logic [etrb_pkg::CNT_W-1:0]      tally_sum;
    logic [etrb_pkg::ADDR_W-1:0]     slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= etrb_pkg::ST_IDLE;
            enable_reg    <= 1'b0;
            wp_reg        <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            wp_reg        <= wp_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        kind_reg  <= kind_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        tally_reg <= tally_next;
        addr_reg  <= addr_next;
        res_reg   <= res_next;
    end

    // One item at a time: every memory access of an item is issued after the
    // write of the previous emit has landed, so no forwarding is needed.
    assign s_ready = (state_reg == etrb_pkg::ST_IDLE) && !res_valid_reg;
    assign accept  = s_valid && s_ready;
    assign n_cur   = etrb_pkg::stored_count(total_reg);

    always_comb begin
        state_next     = state_reg;
        enable_next    = enable_reg;
        wp_next        = wp_reg;
        total_next     = total_reg;
        found_next     = found_reg;
        kind_next      = kind_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        tally_next     = tally_reg;
        addr_next      = addr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        wr.en          = 1'b0;
        wr.addr        = wp_reg;
        wr.data        = s_entry;
        rd.en          = 1'b0;
        rd.addr        = addr_reg;
        tally_sum      = tally_reg + etrb_pkg::CNT_W'(rd_data.kind == kind_reg);
        slot           = etrb_pkg::slot_of(wp_reg, etrb_pkg::ADDR_W'(s_cursor));

        if (cfg_valid) begin
            enable_next = cfg_data;
        end
        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            etrb_pkg::ST_IDLE: begin
                if (accept) begin
                    res_next       = '0;
                    res_next.tally = etrb_pkg::TALLY_W'(n_cur);
                    res_next.total = total_reg;
                    case (s_mode)
                        etrb_pkg::MODE_EMIT: begin
                            if (enable_reg) begin
                                wr.en      = 1'b1;
                                wp_next    = etrb_pkg::addr_inc(wp_reg);
                                total_next = total_reg + 1'b1;
                            end
                            res_next.tally =
                                etrb_pkg::TALLY_W'(etrb_pkg::stored_count(total_next));
                            res_next.total = total_next;
                            res_valid_next = 1'b1;
                        end
                        etrb_pkg::MODE_READ: begin
                            found_next = 32'(s_cursor) < 32'(n_cur);
                            rd.en      = 1'b1;
                            rd.addr    = slot;
                            state_next = etrb_pkg::ST_READ;
                        end
                        etrb_pkg::MODE_COUNT: begin
                            kind_next  = s_entry.kind;
                            n_next     = n_cur;
                            tally_next = '0;
                            if (n_cur == '0) begin
                                res_next.tally = '0;
                                res_valid_next = 1'b1;
                            end else begin
                                rd.en      = 1'b1;
                                rd.addr    = etrb_pkg::slot_of(wp_reg, '0);
                                addr_next  = rd.addr;
                                idx_next   = etrb_pkg::CNT_W'(1);
                                state_next = etrb_pkg::ST_COUNT;
                            end
                        end
                        etrb_pkg::MODE_CLEAR: begin
                            wp_next        = '0;
                            total_next     = '0;
                            res_next.tally = '0;
                            res_next.total = '0;
                            res_valid_next = 1'b1;
                        end
                        default: begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            etrb_pkg::ST_READ: begin
                res_next       = '0;
                res_next.found = found_reg;
                res_next.entry = found_reg ? rd_data : '0;
                res_next.tally = etrb_pkg::TALLY_W'(n_cur);
                res_next.total = total_reg;
                res_valid_next = 1'b1;
                state_next     = etrb_pkg::ST_IDLE;
            end
            etrb_pkg::ST_COUNT: begin
                // Read data belongs to walk step idx_reg - 1; the next read is
                // issued in the same cycle, so the port reads every cycle of the walk but the last.
                if (idx_reg == n_reg) begin
                    res_next       = '0;
                    res_next.tally = etrb_pkg::TALLY_W'(tally_sum);
                    res_next.total = total_reg;
                    res_valid_next = 1'b1;
                    state_next     = etrb_pkg::ST_IDLE;
                end else begin
                    rd.en      = 1'b1;
                    rd.addr    = etrb_pkg::addr_dec(addr_reg);
                    addr_next  = rd.addr;
                    idx_next   = idx_reg + 1'b1;
                    tally_next = tally_sum;
                end
            end
            default: begin
                state_next = etrb_pkg::ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hw/rtl/etrb_checker.sv */
`timescale 1ns / 1ps
`include "event_trace_ring_buffer_assert.svh"

module etrb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic                            m_tuser,
    input logic [etrb_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ENTRY_W = $bits(etrb_pkg::entry_t);

    logic [etrb_pkg::TALLY_W-1:0] tally;
    assign tally = m_tdata[ENTRY_W +: etrb_pkg::TALLY_W];

    `ETRB_ASSERT_ALWAYS(a_reset_empties_output, !aresetn |=> !m_tvalid, "result shown after reset")

    `ETRB_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `ETRB_ASSERT(a_miss_zero_entry, m_tvalid && !m_tuser |-> m_tdata[ENTRY_W-1:0] == '0, "entry fields set without found")

    `ETRB_ASSERT(a_found_nonempty, m_tvalid && m_tuser |-> tally != '0, "entry found in an empty ring")

    `ETRB_ASSERT(a_tally_bounded, m_tvalid |-> 32'(tally) <= 32'(etrb_pkg::DEPTH), "tally beyond ring depth")

endmodule

bind event_trace_ring_buffer etrb_checker u_etrb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
